// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the gain scheduler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ACGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define ACGS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/acgs_pkg.sv =====
// ----------------------------------------------------------------------------
// acgs_pkg
// Types, constants and codes shared by the crossfade gain scheduler.
// ----------------------------------------------------------------------------
package acgs_pkg;

  localparam int DEF_MAX_VOICES = 8;
  localparam int RESULT_CAP     = 8;
  localparam int RES_CNT_W      = $clog2(RESULT_CAP + 1);

  localparam logic [15:0] GAIN_ONE      = 16'd32768;
  localparam logic [15:0] GAIN_STEP_RST = 16'd328;

  // Register index codes of the configuration port.
  localparam logic REG_GAIN_STEP = 1'b0;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_PLAY = 2'd1,
    REQ_STOP = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ACT_RUNNING  = 3'd0,
    ACT_PAUSED   = 3'd1,
    ACT_STARTED  = 3'd2,
    ACT_UPDATED  = 3'd3,
    ACT_REMOVED  = 3'd4,
    ACT_REJECTED = 3'd5,
    ACT_CLEARED  = 3'd6
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NW_RD,
    ST_NW_CK,
    ST_WK_RD,
    ST_WK_PR,
    ST_PL_RD,
    ST_PL_CK,
    ST_PL_NEW,
    ST_SH_RD,
    ST_SH_WR,
    ST_PL_PUT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  buffer_id;
    logic [15:0] volume_factor;
    logic        paused;
    logic        time_advanced;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  voice_buffer_id;
    logic [15:0] effective_gain;
    logic [2:0]  action;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  buf_id;
    logic [15:0] gain;
    logic [15:0] factor;
  } voice_t;

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    logic        push;
    logic        last;
    logic [7:0]  buf_id;
    logic [15:0] factor;
    logic [15:0] gain;
    act_t        action;
  } emit_t;

  function automatic logic [15:0] sat_one(input logic [15:0] v);
    return (v > GAIN_ONE) ? GAIN_ONE : v;
  endfunction

endpackage

// ===== hdl/audio_crossfade_gain_scheduler.sv =====
// A fading tick walks the N voices, one read per voice and one write-back per
// surviving voice, before the next input is taken; a play scans the table and,
// on a match, shifts the later voices down; stop, paused and idle ticks only decode.
// One item at a time: no new input is taken until the last one is done; a result
// that cannot leave holds the sequencer.
// Reset: synchronous, active low; clears the voice count, total gain and
// handshake state. The voice table is not cleared, only its count.
// ----------------------------------------------------------------------------
// audio_crossfade_gain_scheduler
// Crossfade gain scheduler for looping audio voices.
// ----------------------------------------------------------------------------
module audio_crossfade_gain_scheduler #(
  parameter int MAX_VOICES = acgs_pkg::DEF_MAX_VOICES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acgs_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import acgs_pkg::*;

  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  logic [15:0]   gain_step;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  voice_t        wr_data;
  logic [AW-1:0] rd_addr;
  voice_t        rd_data;
  emit_t         emit;
  logic          out_free;

  acgs_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .gain_step  (gain_step)
  );

  acgs_voice_mem #(.MAX_VOICES(MAX_VOICES)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  acgs_ctrl #(.MAX_VOICES(MAX_VOICES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .gain_step(gain_step),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .emit     (emit),
    .out_free (out_free)
  );

  acgs_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit     (emit),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== hdl/acgs_voice_mem.sv =====
// ----------------------------------------------------------------------------
// acgs_voice_mem
// Voice table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module acgs_voice_mem #(
  parameter int MAX_VOICES = acgs_pkg::DEF_MAX_VOICES,
  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  acgs_pkg::voice_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output acgs_pkg::voice_t rd_data
);
  import acgs_pkg::*;

  voice_t mem [MAX_VOICES];
  voice_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/acgs_cfg.sv =====
// ----------------------------------------------------------------------------
// acgs_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module acgs_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [15:0] gain_step
);
  import acgs_pkg::*;

  logic [15:0] gain_step_r;
  logic        sel_step;

  assign sel_step = (cfg_paddr[2] == REG_GAIN_STEP) && (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_step_r <= GAIN_STEP_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_step) begin
      gain_step_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = sel_step ? {16'b0, gain_step_r} : 32'b0;
  assign cfg_pready = 1'b1;
  assign gain_step  = gain_step_r;

endmodule

// ===== hdl/acgs_out.sv =====
// ----------------------------------------------------------------------------
// acgs_out
// Result register: scales the fade gain by the volume factor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acgs_out (
  input  logic                clk,
  input  logic                rst_n,
  input  acgs_pkg::emit_t     emit,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output acgs_pkg::out_item_t out_data
);
  import acgs_pkg::*;

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [31:0] prod;
  logic [31:0] rounded;

  // Q1.15 product, rounded to nearest with ties up.
  assign prod    = 32'(emit.factor) * 32'(emit.gain);
  assign rounded = prod + 32'd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      out_data_r.voice_buffer_id <= emit.buf_id;
      out_data_r.effective_gain  <= rounded[30:15];
      out_data_r.action          <= emit.action;
      out_data_r.last            <= emit.last;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ACGS_ASSERT_IMP(a_push_free, emit.push, out_free, "result pushed over a pending transfer")

endmodule

// ===== hdl/acgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// acgs_ctrl
// Request sequencer: walks the voice table through read-modify-write passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acgs_ctrl #(
  parameter int MAX_VOICES = acgs_pkg::DEF_MAX_VOICES,
  localparam int AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  acgs_pkg::in_item_t in_data,
  input  logic [15:0]        gain_step,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output acgs_pkg::voice_t   wr_data,
  output logic [AW-1:0]      rd_addr,
  input  acgs_pkg::voice_t   rd_data,
  output acgs_pkg::emit_t    emit,
  input  logic               out_free
);
  import acgs_pkg::*;

  state_t               state_r, state_nxt;
  in_item_t             item_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [16:0]          total_r, total_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        w_r, w_nxt;
  logic [15:0]          g_r, g_nxt;
  logic [15:0]          old_r, old_nxt;
  logic signed [18:0]   d1_r, d1_nxt;
  logic signed [18:0]   tot_r, tot_nxt;
  logic [15:0]          pg_r, pg_nxt;
  emit_t                hold_r, hold_nxt;
  logic                 hold_v_r, hold_v_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;

  // Result request from the current state.
  logic        want;
  logic [7:0]  e_buf;
  logic [15:0] e_fac;
  logic [15:0] e_gain;
  act_t        e_act;
  logic        progress;

  // Walk arithmetic.
  logic [15:0]        fac_sat;
  logic [15:0]        step_sat;
  logic [16:0]        gsum;
  logic [15:0]        g_new;
  logic [CW-1:0]      nw;
  logic               is_nw;
  logic signed [18:0] cur;
  logic [15:0]        prev_gain;
  logic signed [18:0] excess;
  logic signed [18:0] red;
  logic signed [18:0] cur_new;
  logic               removed;

  assign fac_sat   = sat_one(item_r.volume_factor);
  assign step_sat  = sat_one(gain_step);
  assign nw        = cnt_r - CW'(1);
  assign gsum      = {1'b0, rd_data.gain} + {1'b0, step_sat};
  assign g_new     = (gsum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gsum[15:0];
  assign is_nw     = (idx_r == nw);
  assign prev_gain = is_nw ? old_r : rd_data.gain;
  assign cur       = is_nw ? 19'(g_r) : 19'(rd_data.gain);
  assign excess    = tot_r - 19'sd32768;

  always_comb begin
    red = cur;
    if (d1_r < red) red = d1_r;
    if (excess < red) red = excess;
    if (excess == 19'sd0) red = 19'sd0;
  end

  assign cur_new = cur - red;
  assign removed = (excess != 19'sd0) && (cur_new == 19'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      total_r  <= '0;
      hold_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      hold_v_r <= hold_v_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    idx_r  <= idx_nxt;
    w_r    <= w_nxt;
    g_r    <= g_nxt;
    old_r  <= old_nxt;
    d1_r   <= d1_nxt;
    tot_r  <= tot_nxt;
    pg_r   <= pg_nxt;
    hold_r <= hold_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    w_nxt     = w_r;
    g_nxt     = g_r;
    old_nxt   = old_r;
    d1_nxt    = d1_r;
    tot_nxt   = tot_r;
    pg_nxt    = pg_r;
    in_ready  = 1'b0;
    rd_addr   = idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = w_r[AW-1:0];
    wr_data   = rd_data;
    want      = 1'b0;
    e_buf     = '0;
    e_fac     = '0;
    e_gain    = '0;
    e_act     = ACT_RUNNING;

    // A result may stall the step only when the held one cannot leave.
    progress  = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (item_r.req_type)
          REQ_TICK: begin
            if (item_r.paused) begin
              want      = 1'b1;
              e_act     = ACT_PAUSED;
              state_nxt = ST_FIN;
            end else if (item_r.time_advanced && (cnt_r != '0)) begin
              state_nxt = ST_NW_RD;
            end else begin
              state_nxt = ST_FIN;
            end
          end
          REQ_PLAY: begin
            idx_nxt   = '0;
            state_nxt = ST_PL_RD;
          end
          REQ_STOP: begin
            want      = 1'b1;
            e_act     = ACT_CLEARED;
            cnt_nxt   = '0;
            total_nxt = '0;
            state_nxt = ST_FIN;
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_NW_RD: begin
        rd_addr   = nw[AW-1:0];
        state_nxt = ST_NW_CK;
      end
      ST_NW_CK: begin
        rd_addr   = nw[AW-1:0];
        old_nxt   = rd_data.gain;
        g_nxt     = g_new;
        d1_nxt    = 19'(g_new) - 19'(rd_data.gain);
        tot_nxt   = 19'(total_r) + 19'(g_new) - 19'(rd_data.gain);
        idx_nxt   = '0;
        w_nxt     = '0;
        state_nxt = ST_WK_RD;
      end
      ST_WK_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = w_r;
          total_nxt = tot_r[16:0];
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_WK_PR;
        end
      end
      ST_WK_PR: begin
        if (removed) begin
          want  = 1'b1;
          e_buf = rd_data.buf_id;
          e_act = ACT_REMOVED;
        end else if (cur_new[15:0] != prev_gain) begin
          want   = 1'b1;
          e_buf  = rd_data.buf_id;
          e_fac  = rd_data.factor;
          e_gain = cur_new[15:0];
        end
        progress = !want || (n_r >= RES_CNT_W'(RESULT_CAP)) || !hold_v_r || out_free;
        if (progress) begin
          // Survivors are packed toward the oldest end as the walk goes.
          wr_en          = !removed;
          wr_data.buf_id = rd_data.buf_id;
          wr_data.gain   = cur_new[15:0];
          wr_data.factor = rd_data.factor;
          if (!removed) w_nxt = w_r + CW'(1);
          tot_nxt   = tot_r - red;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_WK_RD;
        end
      end
      ST_PL_RD: begin
        state_nxt = (idx_r == cnt_r) ? ST_PL_NEW : ST_PL_CK;
      end
      ST_PL_CK: begin
        if (rd_data.buf_id == item_r.buffer_id) begin
          pg_nxt    = rd_data.gain;
          state_nxt = ST_SH_RD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_PL_RD;
        end
      end
      ST_PL_NEW: begin
        want  = 1'b1;
        e_buf = item_r.buffer_id;
        if (cnt_r >= CW'(MAX_VOICES)) begin
          e_act = ACT_REJECTED;
        end else begin
          e_act          = ACT_STARTED;
          wr_en          = 1'b1;
          wr_addr        = cnt_r[AW-1:0];
          wr_data.buf_id = item_r.buffer_id;
          wr_data.gain   = '0;
          wr_data.factor = fac_sat;
          cnt_nxt        = cnt_r + CW'(1);
        end
        state_nxt = ST_FIN;
      end
      ST_SH_RD: begin
        if ((idx_r + CW'(1)) < cnt_r) begin
          rd_addr   = idx_r[AW-1:0] + AW'(1);
          state_nxt = ST_SH_WR;
        end else begin
          state_nxt = ST_PL_PUT;
        end
      end
      ST_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_SH_RD;
      end
      ST_PL_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = nw[AW-1:0];
        wr_data.buf_id = item_r.buffer_id;
        wr_data.gain   = pg_r;
        wr_data.factor = fac_sat;
        want           = 1'b1;
        e_buf          = item_r.buffer_id;
        e_fac          = fac_sat;
        e_gain         = pg_r;
        e_act          = ACT_UPDATED;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        progress = !hold_v_r || out_free;
        if (progress) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result holding: the previous result leaves once the next one is known,
  // so the final one can carry the last flag.
  always_comb begin
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    n_nxt      = n_r;
    emit       = hold_r;
    emit.push  = 1'b0;
    emit.last  = 1'b0;
    if (state_r == ST_IDLE) begin
      n_nxt = '0;
    end
    if (state_r == ST_FIN) begin
      if (hold_v_r && out_free) begin
        emit.push  = 1'b1;
        emit.last  = 1'b1;
        hold_v_nxt = 1'b0;
      end
    end else if (want && progress && (n_r < RES_CNT_W'(RESULT_CAP))) begin
      if (hold_v_r) emit.push = 1'b1;
      hold_nxt.buf_id = e_buf;
      hold_nxt.factor = e_fac;
      hold_nxt.gain   = e_gain;
      hold_nxt.action = e_act;
      hold_nxt.push   = 1'b0;
      hold_nxt.last   = 1'b0;
      hold_v_nxt      = 1'b1;
      n_nxt           = n_r + RES_CNT_W'(1);
    end
  end

  `ACGS_ASSERT(a_cnt_max, cnt_r <= CW'(MAX_VOICES), "voice count beyond table size")
  `ACGS_ASSERT_IMP(a_idle_empty, state_r == ST_IDLE, !hold_v_r, "result held while idle")
  `ACGS_ASSERT_IMP(a_pack_order, wr_en && state_r == ST_WK_PR, w_r <= idx_r,
                   "packed write ahead of walk")

endmodule
